### rtl/hsi_pkg.sv
// ----------------------------------------------------------------------------
// hsi_pkg
// Shared types and codes for the heater safety interlock: input and result
// beats, configuration register set, interlock state and trip causes.
// ----------------------------------------------------------------------------
package hsi_pkg;

    // item kinds
    typedef enum logic [1:0] {
        ACT_RESTART = 2'd0,
        ACT_BEAT    = 2'd1,
        ACT_CHECK   = 2'd2
    } t_action;

    // trip causes
    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_BEAT    = 3'd1,
        CAUSE_PROBE   = 3'd2,
        CAUSE_HOT     = 3'd3,
        CAUSE_RUNAWAY = 3'd4
    } t_cause;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_COMMS_TIMEOUT = 3'd0,
        CFG_BAD_LIMIT     = 3'd1,
        CFG_MAX_TEMP      = 3'd2,
        CFG_ARM_BELOW     = 3'd3,
        CFG_HEAT_PCT      = 3'd4,
        CFG_WINDOW_MS     = 3'd5,
        CFG_MIN_RISE      = 3'd6
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // configuration reset values
    localparam logic [31:0]        RST_COMMS_TIMEOUT = 32'd10000;
    localparam logic [15:0]        RST_BAD_LIMIT     = 16'd5;
    localparam logic signed [15:0] RST_MAX_TEMP      = 16'sd3840;
    localparam logic signed [15:0] RST_ARM_BELOW     = 16'sd3200;
    localparam logic [6:0]         RST_HEAT_PCT      = 7'd80;
    localparam logic [31:0]        RST_WINDOW_MS     = 32'd60000;
    localparam logic [14:0]        RST_MIN_RISE      = 15'd80;

    // input beat
    typedef struct packed {
        logic [1:0]         action;
        logic [31:0]        time_ms;
        logic signed [15:0] temp_sample;
        logic               temp_valid;
        logic [6:0]         heater_pct;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic       heat_allowed;
        logic [2:0] trip_cause;
    } t_out_item;

    // configuration register set
    typedef struct packed {
        logic [31:0]        comms_timeout_ms;
        logic [15:0]        bad_probe_limit;
        logic signed [15:0] max_temp;
        logic signed [15:0] runaway_arm_below;
        logic [6:0]         runaway_heat_pct;
        logic [31:0]        runaway_window_ms;
        logic [14:0]        runaway_min_rise;
    } t_cfg;

    // interlock state
    typedef struct packed {
        logic [31:0]        last_beat_time;
        logic [15:0]        bad_read_count;
        logic [31:0]        window_start_time;
        logic signed [15:0] window_start_temp;
        logic               window_armed;
    } t_state;

endpackage

### rtl/hsi_check.sv
// ----------------------------------------------------------------------------
// hsi_check
// Decision logic for one item: computes the result beat and the next
// interlock state from the registered item, configuration and state.
// ----------------------------------------------------------------------------
module hsi_check
    import hsi_pkg::*;
(
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_state    i_state,
    output t_out_item o_result,
    output t_state    o_state
);

    logic [31:0]        w_beat_age;
    logic               w_beat_stale;
    logic [15:0]        w_cnt_inc;
    logic               w_probe_trip;
    logic               w_hot;
    logic               w_disarm;
    logic [31:0]        w_win_age;
    logic               w_win_due;
    logic signed [16:0] w_rise;
    logic               w_rise_low;

    // wrapping ages against the stored timestamps
    assign w_beat_age   = i_item.time_ms - i_state.last_beat_time;
    assign w_beat_stale = w_beat_age > i_cfg.comms_timeout_ms;
    assign w_win_age    = i_item.time_ms - i_state.window_start_time;
    assign w_win_due    = w_win_age >= i_cfg.runaway_window_ms;

    // saturating bad read count
    assign w_cnt_inc    = (&i_state.bad_read_count) ? i_state.bad_read_count
                                                    : i_state.bad_read_count + 16'd1;
    assign w_probe_trip = w_cnt_inc >= i_cfg.bad_probe_limit;

    // temperature tests
    assign w_hot      = $signed(i_item.temp_sample) >= $signed(i_cfg.max_temp);
    assign w_disarm   = ($signed(i_item.temp_sample) >= $signed(i_cfg.runaway_arm_below))
                      || (i_item.heater_pct < i_cfg.runaway_heat_pct);
    assign w_rise     = $signed({i_item.temp_sample[15], i_item.temp_sample})
                      - $signed({i_state.window_start_temp[15], i_state.window_start_temp});
    assign w_rise_low = w_rise < $signed({2'b00, i_cfg.runaway_min_rise});

    // priority of trips and state update
    always_comb begin
        o_state               = i_state;
        o_result.heat_allowed = 1'b1;
        o_result.trip_cause   = CAUSE_NONE;
        case (t_action'(i_item.action))
            ACT_RESTART: begin
                o_state.last_beat_time = i_item.time_ms;
                o_state.bad_read_count = '0;
                o_state.window_armed   = 1'b0;
            end
            ACT_BEAT: begin
                o_state.last_beat_time = i_item.time_ms;
            end
            ACT_CHECK: begin
                if (w_beat_stale) begin
                    o_result.heat_allowed = 1'b0;
                    o_result.trip_cause   = CAUSE_BEAT;
                end else if (!i_item.temp_valid) begin
                    o_state.bad_read_count = w_cnt_inc;
                    if (w_probe_trip) begin
                        o_result.heat_allowed = 1'b0;
                        o_result.trip_cause   = CAUSE_PROBE;
                    end else begin
                        o_state.window_armed = 1'b0;
                    end
                end else begin
                    o_state.bad_read_count = '0;
                    if (w_hot) begin
                        o_result.heat_allowed = 1'b0;
                        o_result.trip_cause   = CAUSE_HOT;
                    end else if (w_disarm) begin
                        o_state.window_armed = 1'b0;
                    end else if (!i_state.window_armed) begin
                        o_state.window_armed      = 1'b1;
                        o_state.window_start_time = i_item.time_ms;
                        o_state.window_start_temp = i_item.temp_sample;
                    end else if (w_win_due) begin
                        if (w_rise_low) begin
                            o_result.heat_allowed = 1'b0;
                            o_result.trip_cause   = CAUSE_RUNAWAY;
                        end else begin
                            o_state.window_start_time = i_item.time_ms;
                            o_state.window_start_temp = i_item.temp_sample;
                        end
                    end
                end
            end
            default: begin
                // unused action code: no state change, heat allowed
                o_state = i_state;
            end
        endcase
    end

endmodule

### rtl/heater_safety_interlock.sv
// ----------------------------------------------------------------------------
// heater_safety_interlock
// Heater cut-off interlock with heartbeat, probe, over-temperature and
// runaway checks, one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries restart,
//   heartbeat and check beats, each with a millisecond timestamp.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns one
//   beat per input beat, in order: heat_allowed and trip_cause.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes one register per beat; o_cfg_ready is always high and writes
//   should only happen while no beat is in flight. Unknown indexes are ignored.
//   Path: a beat passes the input register, then the result register (o_out_data).
//   Throughput: one beat per cycle when not stalled; the interlock state is read
//   and updated between the two registers, so back-to-back beats see each
//   other's effects.
//   Receiver stall: the result register holds; the input register keeps its
//   beat and o_in_stall rises only once both registers are full.
//   Reset (i_rst_n low, synchronous): configuration returns to its defaults,
//   the state clears (window unarmed, counts zero) and both registers empty.
// ----------------------------------------------------------------------------
module heater_safety_interlock
    import hsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out;
    logic      w_adv;
    logic      w_fire;

    // pipeline flow
    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_fire      = w_adv && r_in_valid;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // decision logic
    hsi_check u_check (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    // interlock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.comms_timeout_ms  <= RST_COMMS_TIMEOUT;
            r_cfg.bad_probe_limit   <= RST_BAD_LIMIT;
            r_cfg.max_temp          <= RST_MAX_TEMP;
            r_cfg.runaway_arm_below <= RST_ARM_BELOW;
            r_cfg.runaway_heat_pct  <= RST_HEAT_PCT;
            r_cfg.runaway_window_ms <= RST_WINDOW_MS;
            r_cfg.runaway_min_rise  <= RST_MIN_RISE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COMMS_TIMEOUT: r_cfg.comms_timeout_ms  <= i_cfg_data;
                CFG_BAD_LIMIT:     r_cfg.bad_probe_limit   <= i_cfg_data[15:0];
                CFG_MAX_TEMP:      r_cfg.max_temp          <= i_cfg_data[15:0];
                CFG_ARM_BELOW:     r_cfg.runaway_arm_below <= i_cfg_data[15:0];
                CFG_HEAT_PCT:      r_cfg.runaway_heat_pct  <= i_cfg_data[6:0];
                CFG_WINDOW_MS:     r_cfg.runaway_window_ms <= i_cfg_data;
                CFG_MIN_RISE:      r_cfg.runaway_min_rise  <= i_cfg_data[14:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // checks
    a_cause_matches_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.heat_allowed == (o_out_data.trip_cause == CAUSE_NONE)))
        else $error("heat_allowed disagrees with trip_cause");

    a_non_check_allows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.action != ACT_CHECK) |=> (o_out_valid && o_out_data.heat_allowed))
        else $error("restart or heartbeat did not allow heat");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.action == ACT_RESTART)
            |=> (r_state.bad_read_count == '0 && !r_state.window_armed))
        else $error("restart did not clear probe count and window");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule

### dv/hsi_checker.sv
// ----------------------------------------------------------------------------
// hsi_checker
// Watches the input, result and configuration channels of the heater safety
// interlock, predicts one verdict per accepted input beat from its own copy
// of the registers and interlock state, and compares every result beat with
// the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module hsi_checker
    import hsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg      regs;
    t_state    ilk;
    t_out_item verdict_q[$];
    int        fails = 0;

    // heat cut with the given cause
    function automatic t_out_item cut_heat(input t_cause cause);
        t_out_item res;
        res.heat_allowed = 1'b0;
        res.trip_cause   = cause;
        return res;
    endfunction

    // verdict for one beat, advancing the interlock state
    function automatic t_out_item interlock_verdict(input t_in_item it);
        t_out_item          res;
        logic [31:0]        beat_age;
        logic [31:0]        window_age;
        logic signed [15:0] temp;
        logic signed [15:0] hot_limit;
        logic signed [15:0] arm_limit;
        logic signed [15:0] start_temp;
        int                 rise;
        res.heat_allowed = 1'b1;
        res.trip_cause   = CAUSE_NONE;
        temp       = it.temp_sample;
        hot_limit  = regs.max_temp;
        arm_limit  = regs.runaway_arm_below;
        start_temp = ilk.window_start_temp;
        beat_age   = it.time_ms - ilk.last_beat_time;
        window_age = it.time_ms - ilk.window_start_time;
        rise       = int'(temp) - int'(start_temp);
        case (it.action)
            ACT_RESTART: begin
                ilk.last_beat_time = it.time_ms;
                ilk.bad_read_count = '0;
                ilk.window_armed   = 1'b0;
            end
            ACT_BEAT: begin
                ilk.last_beat_time = it.time_ms;
            end
            ACT_CHECK: begin
                if (beat_age > regs.comms_timeout_ms) begin
                    res = cut_heat(CAUSE_BEAT);
                end else if (!it.temp_valid) begin
                    // bad-read count saturates
                    if (ilk.bad_read_count != 16'hFFFF)
                        ilk.bad_read_count = ilk.bad_read_count + 16'd1;
                    if (ilk.bad_read_count >= regs.bad_probe_limit)
                        res = cut_heat(CAUSE_PROBE);
                    else
                        ilk.window_armed = 1'b0;
                end else begin
                    ilk.bad_read_count = '0;
                    if (temp >= hot_limit) begin
                        res = cut_heat(CAUSE_HOT);
                    end else if (temp >= arm_limit
                                 || it.heater_pct < regs.runaway_heat_pct) begin
                        ilk.window_armed = 1'b0;
                    end else if (!ilk.window_armed) begin
                        ilk.window_armed      = 1'b1;
                        ilk.window_start_time = it.time_ms;
                        ilk.window_start_temp = temp;
                    end else if (window_age >= regs.runaway_window_ms) begin
                        if (rise < int'(regs.runaway_min_rise)) begin
                            res = cut_heat(CAUSE_RUNAWAY);
                        end else begin
                            ilk.window_start_time = it.time_ms;
                            ilk.window_start_temp = temp;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // register write as the block takes it, unknown indexes dropped
    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_COMMS_TIMEOUT: regs.comms_timeout_ms  = data;
            CFG_BAD_LIMIT:     regs.bad_probe_limit   = data[15:0];
            CFG_MAX_TEMP:      regs.max_temp          = data[15:0];
            CFG_ARM_BELOW:     regs.runaway_arm_below = data[15:0];
            CFG_HEAT_PCT:      regs.runaway_heat_pct  = data[6:0];
            CFG_WINDOW_MS:     regs.runaway_window_ms = data;
            CFG_MIN_RISE:      regs.runaway_min_rise  = data[14:0];
            default: begin
            end
        endcase
    endfunction

    // watch all channels at each edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            regs.comms_timeout_ms  = RST_COMMS_TIMEOUT;
            regs.bad_probe_limit   = RST_BAD_LIMIT;
            regs.max_temp          = RST_MAX_TEMP;
            regs.runaway_arm_below = RST_ARM_BELOW;
            regs.runaway_heat_pct  = RST_HEAT_PCT;
            regs.runaway_window_ms = RST_WINDOW_MS;
            regs.runaway_min_rise  = RST_MIN_RISE;
            ilk = '0;
            verdict_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                verdict_q.push_back(interlock_verdict(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no input beat outstanding: %p", i_out_data);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_data.heat_allowed !== want.heat_allowed) begin
                        $error("heat_allowed: expected %0d, got %0d",
                               want.heat_allowed, i_out_data.heat_allowed);
                        fails++;
                    end
                    if (i_out_data.trip_cause !== want.trip_cause) begin
                        $error("trip_cause: expected %0d, got %0d",
                               want.trip_cause, i_out_data.trip_cause);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the heater safety interlock: a directed opening
// over the trip causes and boundaries, a bad-read run under the widest limit,
// then random beats under several register settings with bursty input and
// a receiver that stalls in changing patterns. hsi_checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;
    import hsi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned           CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0]            ACT_UNDEF   = 2'd3;
    localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED  = 3'd7;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    t_in_item              in_data    = '0;
    logic                  out_stall  = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  cfg_ready;
    int                    pending;
    int                    fail_count;

    // stimulus-side view of the registers and the plant
    t_cfg        cfg_now;
    logic [31:0] clock_ms   = '0;
    int          temp_track = 0;
    int          dead_left  = 0;
    int unsigned cycle_count = 0;
    int          recv_mode  = 0;
    int          recv_left  = 0;

    heater_safety_interlock i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hsi_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** heater_safety_interlock: FAILED **");
            $finish;
        end
    end

    // receiver stall: free, light, heavy or periodic, switching now and then
    always @(posedge clk) begin
        if (recv_left == 0) begin
            recv_mode <= $urandom_range(0, 3);
            recv_left <= $urandom_range(20, 300);
        end else begin
            recv_left <= recv_left - 1;
        end
        case (recv_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((recv_left % 7) < 2);
        endcase
    end

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic t_in_item mk_beat(input logic [1:0] act, input logic [31:0] t,
                                         input int temp, input logic ok, input int pct);
        t_in_item it;
        it.action      = act;
        it.time_ms     = t;
        it.temp_sample = sat16(temp);
        it.temp_valid  = ok;
        it.heater_pct  = 7'(pct);
        return it;
    endfunction

    // next random beat: advancing clock, drifting probe, bad-read runs, noise
    function automatic t_in_item next_item();
        t_in_item           it;
        int                 roll;
        int                 step_cap;
        int                 ceiling;
        longint             span;
        logic signed [15:0] hot;
        logic signed [15:0] arm;
        hot = cfg_now.max_temp;
        arm = cfg_now.runaway_arm_below;
        span = (cfg_now.comms_timeout_ms < cfg_now.runaway_window_ms)
             ? longint'(cfg_now.comms_timeout_ms) : longint'(cfg_now.runaway_window_ms);
        if (span > 40000)
            span = 40000;
        step_cap = int'(span / 3) + 2;
        if ($urandom_range(0, 59) == 0)
            clock_ms += $urandom();
        else
            clock_ms += $urandom_range(0, step_cap);

        // probe creeps up at around the required rise, falls back below arming
        temp_track += int'($urandom_range(0, cfg_now.runaway_min_rise / 3 + 3)) - 3;
        ceiling = (int'(arm) < int'(hot)) ? int'(arm) : int'(hot);
        if (temp_track >= ceiling && $urandom_range(0, 3) != 0)
            temp_track = ceiling - int'($urandom_range(1, 600));
        if (temp_track < -32768)
            temp_track = -32768 + int'($urandom_range(0, 100));

        it.time_ms     = clock_ms;
        it.temp_sample = sat16(temp_track);
        it.temp_valid  = ($urandom_range(0, 15) != 0);
        it.heater_pct  = ($urandom_range(0, 7) != 0)
                       ? 7'($urandom_range(cfg_now.runaway_heat_pct, 100))
                       : 7'($urandom_range(0, 100));
        case ($urandom_range(0, 29))
            0: it.temp_sample = hot;
            1: it.temp_sample = sat16(int'(hot) - 1);
            2: it.temp_sample = arm;
            default: begin
            end
        endcase

        roll = $urandom_range(0, 99);
        if (dead_left > 0) begin
            it.action     = ACT_CHECK;
            it.temp_valid = 1'b0;
            dead_left--;
        end else if (roll < 3) begin
            it.action = ACT_RESTART;
        end else if (roll < 5) begin
            it.action = ACT_UNDEF;
        end else if (roll < 27) begin
            it.action = ACT_BEAT;
        end else begin
            it.action = ACT_CHECK;
            if ($urandom_range(0, 49) == 0)
                dead_left = $urandom_range(1, (cfg_now.bad_probe_limit > 10)
                                              ? 12 : cfg_now.bad_probe_limit + 2);
        end

        // occasional beat with every field random
        if ($urandom_range(0, 11) == 0) begin
            it = t_in_item'(58'({$urandom(), $urandom()}));
            if (it.heater_pct > 7'd100)
                it.heater_pct = 7'($urandom_range(0, 100));
        end
        return it;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.comms_timeout_ms  = $urandom_range(300, 20000);
        c.bad_probe_limit   = 16'($urandom_range(1, 8));
        c.max_temp          = 16'($urandom_range(1600, 4000));
        c.runaway_arm_below = sat16(int'(c.max_temp) - int'($urandom_range(0, 800)));
        c.runaway_heat_pct  = 7'($urandom_range(0, 100));
        c.runaway_window_ms = $urandom_range(1, c.comms_timeout_ms);
        c.runaway_min_rise  = 15'($urandom_range(0, 200));
        return c;
    endfunction

    // one input beat, held until taken
    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending and wait for every verdict to come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // full register set, block idle
    task automatic program_cfg(input t_cfg c, input bit poke_unused);
        cfg_write(CFG_COMMS_TIMEOUT, c.comms_timeout_ms);
        cfg_write(CFG_BAD_LIMIT, {16'd0, c.bad_probe_limit});
        cfg_write(CFG_MAX_TEMP, {{16{c.max_temp[15]}}, c.max_temp});
        cfg_write(CFG_ARM_BELOW, {{16{c.runaway_arm_below[15]}}, c.runaway_arm_below});
        cfg_write(CFG_HEAT_PCT, {25'd0, c.runaway_heat_pct});
        cfg_write(CFG_WINDOW_MS, c.runaway_window_ms);
        cfg_write(CFG_MIN_RISE, {17'd0, c.runaway_min_rise});
        if (poke_unused)
            cfg_write(CFG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
        cfg_now    = c;
        temp_track = int'(c.runaway_arm_below) - int'($urandom_range(1, 600));
        dead_left  = 0;
        @(posedge clk);
    endtask

    // bursts of beats with random gaps, now and then a full drain
    task automatic run_random(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            for (int k = 0; k < burst && left > 0; k++) begin
                send_item(next_item());
                left--;
            end
            if ($urandom_range(0, 49) == 0) begin
                drain();
            end else begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial begin
        t_cfg c;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_now.comms_timeout_ms  = RST_COMMS_TIMEOUT;
        cfg_now.bad_probe_limit   = RST_BAD_LIMIT;
        cfg_now.max_temp          = RST_MAX_TEMP;
        cfg_now.runaway_arm_below = RST_ARM_BELOW;
        cfg_now.runaway_heat_pct  = RST_HEAT_PCT;
        cfg_now.runaway_window_ms = RST_WINDOW_MS;
        cfg_now.runaway_min_rise  = RST_MIN_RISE;

        // directed opening under reset settings
        send_item(mk_beat(ACT_RESTART, 32'd1000, 0, 1'b1, 0));
        send_item(mk_beat(ACT_CHECK, 32'd1500, 320, 1'b1, 0));
        send_item(mk_beat(ACT_CHECK, 32'd1600, 3840, 1'b1, 100));
        send_item(mk_beat(ACT_CHECK, 32'd1700, 3839, 1'b1, 100));
        send_item(mk_beat(ACT_CHECK, 32'd2000, -32768, 1'b1, 100));
        send_item(mk_beat(ACT_BEAT, 32'd61000, 0, 1'b0, 0));
        // rise one short of the minimum, then exactly the minimum
        send_item(mk_beat(ACT_CHECK, 32'd62000, -32768 + 79, 1'b1, 100));
        send_item(mk_beat(ACT_CHECK, 32'd62000, -32768 + 80, 1'b1, 80));
        // bad reads up to the limit and one past
        for (int k = 1; k <= 6; k++)
            send_item(mk_beat(ACT_CHECK, 32'd62000 + k, 100, 1'b0, 100));
        send_item(mk_beat(ACT_CHECK, 32'd62010, 0, 1'b1, 50));
        // heartbeat age exactly at the timeout, then one past
        send_item(mk_beat(ACT_CHECK, 32'd71000, 0, 1'b1, 50));
        send_item(mk_beat(ACT_CHECK, 32'd71001, 0, 1'b1, 50));
        send_item(mk_beat(ACT_UNDEF, 32'd71001, 0, 1'b1, 50));
        send_item(mk_beat(ACT_BEAT, 32'd71001, 0, 1'b0, 0));
        send_item(mk_beat(ACT_CHECK, 32'd71001, 32767, 1'b1, 100));
        send_item(mk_beat(ACT_CHECK, 32'd71002, -32768, 1'b1, 100));
        // timestamp wrap across a restart
        send_item(mk_beat(ACT_RESTART, 32'hFFFF_FF00, 0, 1'b1, 0));
        send_item(mk_beat(ACT_CHECK, 32'h0000_0100, 100, 1'b1, 100));
        send_item(mk_beat(ACT_CHECK, 32'hFFFF_FFFF, 100, 1'b0, 127 - 27));
        drain();

        clock_ms   = 32'd100000;
        temp_track = int'(RST_ARM_BELOW) - 400;
        run_random(300);
        drain();

        // upper extremes: a long bad-read run stays under the widest limit
        c.comms_timeout_ms  = 32'hFFFF_FFFF;
        c.bad_probe_limit   = 16'hFFFF;
        c.max_temp          = 16'sh7FFF;
        c.runaway_arm_below = 16'sh7FFF;
        c.runaway_heat_pct  = 7'd100;
        c.runaway_window_ms = 32'hFFFF_FFFF;
        c.runaway_min_rise  = 15'h7FFF;
        program_cfg(c, 1'b1);
        send_item(mk_beat(ACT_RESTART, clock_ms, 0, 1'b1, 0));
        for (int k = 0; k < 40; k++) begin
            clock_ms += 1;
            send_item(mk_beat(ACT_CHECK, clock_ms, 0, 1'b0, 100));
        end
        send_item(mk_beat(ACT_CHECK, clock_ms, 0, 1'b1, 100));
        send_item(mk_beat(ACT_CHECK, clock_ms, 0, 1'b0, 100));
        run_random(150);
        drain();

        // lower extremes: zero timeout, zero limit, everything hot
        c.comms_timeout_ms  = 32'd0;
        c.bad_probe_limit   = 16'd0;
        c.max_temp          = 16'sh8000;
        c.runaway_arm_below = 16'sh8000;
        c.runaway_heat_pct  = 7'd0;
        c.runaway_window_ms = 32'd0;
        c.runaway_min_rise  = 15'd0;
        program_cfg(c, 1'b0);
        run_random(100);
        drain();

        // zero window and zero limit with the other tests out of the way
        c.comms_timeout_ms  = 32'hFFFF_FFFF;
        c.bad_probe_limit   = 16'd0;
        c.max_temp          = 16'sh7FFF;
        c.runaway_arm_below = 16'sh7FFF;
        c.runaway_heat_pct  = 7'd0;
        c.runaway_window_ms = 32'd0;
        c.runaway_min_rise  = 15'($urandom_range(0, 4));
        program_cfg(c, 1'b0);
        temp_track = 0;
        run_random(150);
        drain();

        // random mid-range settings
        repeat (4) begin
            program_cfg(random_cfg(), 1'b0);
            run_random(200);
            drain();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("** heater_safety_interlock: PASSED **");
        else
            $display("** heater_safety_interlock: FAILED **");
        $finish;
    end

endmodule
